// File: rtl/battery_charge_estimator_core_macros.svh
// ----------------------------------------------------------------------------
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef BATTERY_CHARGE_ESTIMATOR_CORE_MACROS_SVH
`define BATTERY_CHARGE_ESTIMATOR_CORE_MACROS_SVH

// same-cycle implication, reset masks the check
`define BCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bce assertion failed");

// next-cycle implication, reset masks the check
`define BCE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bce assertion failed");

`endif

// File: rtl/bce_pkg.sv
// ----------------------------------------------------------------------------
// bce_pkg
// widths, window constants, lipo table and shared types of the estimator
// ----------------------------------------------------------------------------
package bce_pkg;

	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned MV_W     = 13;
	localparam int unsigned PCT_W    = 7;
	localparam int unsigned AVG_W    = 12;
	localparam int unsigned SUM_W    = 17;

	localparam int unsigned SAMPLES        = 20;
	localparam int unsigned ADC_FULL_SCALE = 4095;
	localparam int unsigned CNT_W          = $clog2(SAMPLES + 1);

	// 3.3 V * 2 (divider) * 1.1 (correction) at full scale, in mV
	localparam int unsigned MV_FULL = 7260;
	localparam int unsigned MV_DEN  = ADC_FULL_SCALE * SAMPLES;

	// serial divider widths: dividend covers sum * MV_FULL
	localparam int unsigned DVS_W = $clog2(MV_DEN + 1);
	localparam int unsigned DVD_W = SUM_W + $clog2(MV_FULL + 1);
	localparam int unsigned CYC_W = $clog2(DVD_W);

	// lipo curve, highest voltage first
	localparam int unsigned TBL_N = 12;
	localparam int unsigned SEG_W = $clog2(TBL_N);
	localparam int unsigned DV_W  = 8;	// widest segment span in mV fits here
	localparam int unsigned DP_W  = 4;	// widest segment span in percent fits here

	localparam logic [MV_W-1:0] TBL_MV [TBL_N] = '{
		13'd4150, 13'd4050, 13'd3960, 13'd3890, 13'd3820, 13'd3750,
		13'd3690, 13'd3620, 13'd3550, 13'd3480, 13'd3300, 13'd3200
	};
	localparam logic [PCT_W-1:0] TBL_PCT [TBL_N] = '{
		7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
		7'd40, 7'd30, 7'd20, 7'd10, 7'd5, 7'd0
	};

	localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
	localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_MV,
		ST_AVG,
		ST_PCT,
		ST_DONE
	} bce_state_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	// segment whose upper point is at or above mv and lower point below it
	function automatic logic [SEG_W-1:0] seg_of(input logic [MV_W-1:0] mv);
		logic [SEG_W-1:0] seg;
		int i;
		seg = '0;
		for (i = 0; i < TBL_N - 1; i++) begin
			if (mv <= TBL_MV[i] && mv > TBL_MV[i+1])
				seg = SEG_W'(i);
		end
		return seg;
	endfunction

endpackage

// File: rtl/bce_acc.sv
// ----------------------------------------------------------------------------
// bce_acc
// running sum and count of the adc samples of one averaging window
// ----------------------------------------------------------------------------
module bce_acc
	import bce_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                clear,
	output logic [SUM_W-1:0]    sum,
	output logic                last
);

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (clear) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			sum_q   <= sum_q + SUM_W'(sample);
			count_q <= count_q + 1'b1;
		end
	end

	assign sum  = sum_q;
	// the beat taken now closes the window
	assign last = (count_q == CNT_W'(SAMPLES - 1));

endmodule

// File: rtl/bce_div.sv
// ----------------------------------------------------------------------------
// bce_div
// restoring divider, one quotient bit per cycle, shared by all three ratios
// ----------------------------------------------------------------------------
module bce_div
	import bce_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W:0]   rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CYC_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   diff;
	logic             fits;

	always_comb begin
		shifted = {rem_q[DVS_W-1:0], dvd_q[DVD_W-1]};
		fits    = (shifted >= {1'b0, dvs_q});
		diff    = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CYC_W'(DVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// quotient bits shift in where dividend bits leave
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff : shifted;
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

// File: rtl/battery_charge_estimator_core.sv
// ----------------------------------------------------------------------------
// battery_charge_estimator_core
// averages adc samples per window, converts to mV, lipo state of charge
// ----------------------------------------------------------------------------
//  channel   dir  handshake                   payload
//  sample    in   sample_valid/sample_stall   adc_sample
//  result    out  result_valid/result_stall   battery_millivolts,
//                                             battery_percent, average_raw
//
//  samples are taken one per cycle while a window fills.
//  the closing beat starts the divisions for the millivolts and the average
//  and, unless the percent is clamped, one for the percent; sample_stall stays
//  high from the closing beat until the result is loaded into the output register.
//  a result waiting in the output register holds back only the hand-over of the
//  next window's result, which keeps sample_stall high until that beat leaves.
//  reset clears the window, the sequencer and the output valid.
// ----------------------------------------------------------------------------
module battery_charge_estimator_core
	import bce_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  logic [SAMPLE_W-1:0] adc_sample,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [MV_W-1:0]     battery_millivolts,
	output logic [PCT_W-1:0]    battery_percent,
	output logic [AVG_W-1:0]    average_raw
);

	bce_state_t state_q, state_d;

	logic             in_beat;
	logic             win_last;
	logic             win_clear;
	logic [SUM_W-1:0] sum;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic cap_mv, cap_avg, cap_pct, cap_full, cap_empty, load_out;

	logic [MV_W-1:0]  mv_q;
	logic [AVG_W-1:0] avg_q;
	logic [PCT_W-1:0] pct_q;
	logic [PCT_W-1:0] base_q;

	logic [SEG_W-1:0]     seg;
	logic [SEG_W-1:0]     seg_lo;
	logic [MV_W-1:0]      span_mv;
	logic [PCT_W-1:0]     span_pct;
	logic [MV_W-1:0]      offset;
	logic [DV_W+DP_W-1:0] seg_prod;
	logic [MV_W-1:0]      mv_sat;

	logic                result_valid_q;
	logic [MV_W-1:0]     mv_out_q;
	logic [PCT_W-1:0]    pct_out_q;
	logic [AVG_W-1:0]    avg_out_q;

	assign in_beat = sample_valid && !sample_stall;

	bce_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (in_beat),
		.sample (adc_sample),
		.clear  (win_clear),
		.sum    (sum),
		.last   (win_last)
	);

	bce_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// interpolation segment of the latched voltage
	always_comb begin
		seg      = seg_of(mv_q);
		seg_lo   = seg + 1'b1;
		span_mv  = TBL_MV[seg] - TBL_MV[seg_lo];
		span_pct = TBL_PCT[seg] - TBL_PCT[seg_lo];
		offset   = mv_q - TBL_MV[seg_lo];
		seg_prod = offset[DV_W-1:0] * span_pct[DP_W-1:0];
	end

	assign mv_sat = (div_rsp.quotient > DVD_W'(MV_FULL)) ? MV_W'(MV_FULL)
		: div_rsp.quotient[MV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		sample_stall     = 1'b1;
		div_req.start    = 1'b0;
		div_req.dividend = DVD_W'(DVD_W'(sum) * DVD_W'(MV_FULL));
		div_req.divisor  = DVS_W'(MV_DEN);
		cap_mv           = 1'b0;
		cap_avg          = 1'b0;
		cap_pct          = 1'b0;
		cap_full         = 1'b0;
		cap_empty        = 1'b0;
		load_out         = 1'b0;
		win_clear        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid && win_last)
					state_d = ST_START;
			end
			ST_START: begin
				div_req.start = 1'b1;
				state_d       = ST_MV;
			end
			ST_MV: begin
				div_req.dividend = DVD_W'(sum);
				div_req.divisor  = DVS_W'(SAMPLES);
				if (div_rsp.done) begin
					cap_mv        = 1'b1;
					div_req.start = 1'b1;
					state_d       = ST_AVG;
				end
			end
			ST_AVG: begin
				div_req.dividend = DVD_W'(seg_prod);
				div_req.divisor  = DVS_W'(span_mv);
				if (div_rsp.done) begin
					cap_avg = 1'b1;
					if (mv_q >= TBL_MV[0]) begin
						cap_full = 1'b1;
						state_d  = ST_DONE;
					end else if (mv_q <= TBL_MV[TBL_N-1]) begin
						cap_empty = 1'b1;
						state_d   = ST_DONE;
					end else begin
						div_req.start = 1'b1;
						state_d       = ST_PCT;
					end
				end
			end
			ST_PCT: begin
				if (div_rsp.done) begin
					cap_pct = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!result_valid_q || !result_stall) begin
					load_out  = 1'b1;
					win_clear = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cap_mv)
			mv_q <= mv_sat;
		if (cap_avg) begin
			avg_q  <= div_rsp.quotient[AVG_W-1:0];
			base_q <= TBL_PCT[seg_lo];
		end
		if (cap_full)
			pct_q <= PCT_FULL;
		else if (cap_empty)
			pct_q <= PCT_EMPTY;
		else if (cap_pct)
			pct_q <= base_q + div_rsp.quotient[PCT_W-1:0];
	end

	// output register, holds the result while the next window collects
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			mv_out_q  <= mv_q;
			pct_out_q <= pct_q;
			avg_out_q <= avg_q;
		end
	end

	assign result_valid       = result_valid_q;
	assign battery_millivolts = mv_out_q;
	assign battery_percent    = pct_out_q;
	assign average_raw        = avg_out_q;

endmodule

// File: rtl/bce_checker.sv
// ----------------------------------------------------------------------------
// bce_checker
// port-level checks of the result beats of the estimator
// ----------------------------------------------------------------------------
`include "battery_charge_estimator_core_macros.svh"

module bce_checker
	import bce_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_stall,
	input logic [MV_W-1:0]  battery_millivolts,
	input logic [PCT_W-1:0] battery_percent,
	input logic [AVG_W-1:0] average_raw
);

	// a stalled result beat holds
	`BCE_ASSERT_NXT(a_res_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(battery_millivolts) && $stable(battery_percent) && $stable(average_raw))

	`BCE_ASSERT_IMP(a_pct_range, clk, arst_n, result_valid, battery_percent <= PCT_FULL)

	// top and bottom of the curve clamp
	`BCE_ASSERT_IMP(a_pct_full, clk, arst_n, result_valid && battery_millivolts >= TBL_MV[0], battery_percent == PCT_FULL)

	`BCE_ASSERT_IMP(a_pct_empty, clk, arst_n, result_valid && battery_millivolts <= TBL_MV[TBL_N-1], battery_percent == PCT_EMPTY)

endmodule

bind battery_charge_estimator_core bce_checker u_bce_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.result_valid       (result_valid),
	.result_stall       (result_stall),
	.battery_millivolts (battery_millivolts),
	.battery_percent    (battery_percent),
	.average_raw        (average_raw)
);
